@@ rtl/core/scaled_glyph_rect_renderer_top_macros.svh @@
// Assertion macros shared by the scaled glyph rectangle renderer RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SCALED_GLYPH_RECT_RENDERER_TOP_MACROS_SVH
`define SCALED_GLYPH_RECT_RENDERER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked outside reset only.
`define SGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SGR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGR_ASSERT(lbl, prop, msg)
`define SGR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/sgr_pkg.sv @@
// Package of the scaled glyph rectangle renderer: payload types, constants
// and the 5x7 font table. No dependencies.
package sgr_pkg;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_DOTS = GLYPH_COLS * GLYPH_ROWS;
	localparam int CELL_W = 6;
	localparam int CELL_H = 8;
	localparam logic [7:0] FONT_FIRST = 8'h20;
	localparam logic [7:0] FONT_LAST = 8'h7E;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RESET = 9'd240;
	localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RESET = 9'd135;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ARG_ERROR = 1'b1;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [7:0]  char_code;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [7:0]  scale;
	} req_t;

	typedef struct packed {
		logic [8:0]  rect_x;
		logic [8:0]  rect_y;
		logic [8:0]  rect_w;
		logic [8:0]  rect_h;
		logic [15:0] rect_color;
		logic        status;
		logic        last;
	} rect_t;

	// A request after classification, as it waits in the queue.
	typedef struct packed {
		logic [15:0]           origin_x;
		logic [15:0]           origin_y;
		logic [15:0]           fg_color;
		logic [15:0]           bg_color;
		logic [7:0]            scale;
		logic [GLYPH_DOTS-1:0] glyph;
		logic                  scale_zero;
	} job_t;

	// Five column bytes, column 0 in the top byte; bit n of a byte is row n.
	function automatic logic [39:0] font_bytes(input logic [7:0] code);
		case (code)
			8'h25: font_bytes = 40'h23_13_08_64_62;
			8'h26: font_bytes = 40'h36_49_29_1A_40;
			8'h27: font_bytes = 40'h00_06_04_00_00;
			8'h2D: font_bytes = 40'h08_08_08_08_08;
			8'h2E: font_bytes = 40'h00_60_60_00_00;
			8'h2F: font_bytes = 40'h20_10_08_04_02;
			8'h30: font_bytes = 40'h3E_51_49_45_3E;
			8'h31: font_bytes = 40'h00_42_7F_40_00;
			8'h32: font_bytes = 40'h42_61_51_49_46;
			8'h33: font_bytes = 40'h21_41_45_4B_31;
			8'h34: font_bytes = 40'h18_14_12_7F_10;
			8'h35: font_bytes = 40'h27_45_45_45_39;
			8'h36: font_bytes = 40'h3C_4A_49_49_30;
			8'h37: font_bytes = 40'h01_71_09_05_03;
			8'h38: font_bytes = 40'h36_49_49_49_36;
			8'h39: font_bytes = 40'h06_49_49_29_1E;
			8'h3A: font_bytes = 40'h00_36_36_00_00;
			8'h41, 8'h61: font_bytes = 40'h7E_11_11_11_7E;
			8'h42, 8'h62: font_bytes = 40'h7F_49_49_49_36;
			8'h43, 8'h63: font_bytes = 40'h3E_41_41_41_22;
			8'h44, 8'h64: font_bytes = 40'h7F_41_41_22_1C;
			8'h45, 8'h65: font_bytes = 40'h7F_49_49_49_41;
			8'h46, 8'h66: font_bytes = 40'h7F_09_09_09_01;
			8'h47, 8'h67: font_bytes = 40'h3E_41_49_49_7A;
			8'h48, 8'h68: font_bytes = 40'h7F_08_08_08_7F;
			8'h49, 8'h69: font_bytes = 40'h00_41_7F_41_00;
			8'h4A, 8'h6A: font_bytes = 40'h20_40_41_3F_01;
			8'h4B, 8'h6B: font_bytes = 40'h7F_08_14_22_41;
			8'h4C, 8'h6C: font_bytes = 40'h7F_40_40_40_40;
			8'h4D, 8'h6D: font_bytes = 40'h7F_02_0C_02_7F;
			8'h4E, 8'h6E: font_bytes = 40'h7F_04_08_10_7F;
			8'h4F, 8'h6F: font_bytes = 40'h3E_41_41_41_3E;
			8'h50, 8'h70: font_bytes = 40'h7F_09_09_09_06;
			8'h51, 8'h71: font_bytes = 40'h3E_41_51_21_5E;
			8'h52, 8'h72: font_bytes = 40'h7F_09_19_29_46;
			8'h53, 8'h73: font_bytes = 40'h46_49_49_49_31;
			8'h54, 8'h74: font_bytes = 40'h01_01_7F_01_01;
			8'h55, 8'h75: font_bytes = 40'h3F_40_40_40_3F;
			8'h56, 8'h76: font_bytes = 40'h1F_20_40_20_1F;
			8'h57, 8'h77: font_bytes = 40'h3F_40_38_40_3F;
			8'h58, 8'h78: font_bytes = 40'h63_14_08_14_63;
			8'h59, 8'h79: font_bytes = 40'h07_08_70_08_07;
			8'h5A, 8'h7A: font_bytes = 40'h61_51_49_45_43;
			8'h5F: font_bytes = 40'h40_40_40_40_40;
			default: font_bytes = 40'h0;
		endcase
	endfunction

	// Dot bit of column c, row r sits at c*GLYPH_ROWS + r: drawing order is
	// ascending bit order. Codes outside the printable range are blank.
	function automatic logic [GLYPH_DOTS-1:0] font_glyph(input logic [7:0] code);
		logic [39:0] b;
		logic [GLYPH_DOTS-1:0] g;
		b = font_bytes(code);
		g = '0;
		if (code >= FONT_FIRST && code <= FONT_LAST) begin
			for (int c = 0; c < GLYPH_COLS; c++) begin
				g[c*GLYPH_ROWS +: GLYPH_ROWS] = b[(32 - 8*c) +: GLYPH_ROWS];
			end
		end
		font_glyph = g;
	endfunction

endpackage

@@ rtl/core/sgr_front.sv @@
// Front end of the glyph renderer: classifies draw requests (font lookup,
// zero scale) and holds them in a short queue. Depends on sgr_pkg.
`include "scaled_glyph_rect_renderer_top_macros.svh"
module sgr_front
	import sgr_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic job_valid,
	input  logic job_pop,
	output job_t job
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = $clog2(DEPTH);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;
	job_t job_in;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) ptr_next = '0;
		else ptr_next = p + PTR_W'(1);
	endfunction

	always_comb begin
		job_in.origin_x = req.origin_x;
		job_in.origin_y = req.origin_y;
		job_in.fg_color = req.fg_color;
		job_in.bg_color = req.bg_color;
		job_in.scale = req.scale;
		job_in.glyph = font_glyph(req.char_code);
		job_in.scale_zero = (req.scale == 8'd0);
	end

	assign req_stall = (count_q == CNT_W'(DEPTH));
	assign push = req_valid && !req_stall;
	assign pop = job_pop && job_valid;
	assign job_valid = (count_q != '0);
	assign job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	`SGR_ASSERT(a_pop_needs_entry, job_pop |-> job_valid, "queue popped while empty")
	`SGR_ASSERT(a_count_up, (push && !pop) |=> (count_q == $past(count_q) + 1'b1),
		"queue count missed a transfer in")
	`SGR_ASSERT(a_count_down, (pop && !push) |=> (count_q == $past(count_q) - 1'b1),
		"queue count missed a pop")

endmodule

@@ rtl/core/sgr_back.sv @@
// Back end of the glyph renderer: walks one queued character, emitting the
// background rectangle and one per lit dot; errors end it. Depends on sgr_pkg.
`include "scaled_glyph_rect_renderer_top_macros.svh"
module sgr_back
	import sgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] screen_width,
	input  logic [8:0] screen_height,
	input  logic       job_valid,
	output logic       job_pop,
	input  job_t       job,
	output logic       rect_valid,
	input  logic       rect_stall,
	output rect_t      rect
);

	localparam rect_t ERR_RECT = '{rect_x: 9'd0, rect_y: 9'd0, rect_w: 9'd0, rect_h: 9'd0,
		rect_color: 16'd0, status: STATUS_ARG_ERROR, last: 1'b1};

	logic busy_q;
	logic [GLYPH_DOTS-1:0] mask_q;
	logic [2:0] row_q;
	logic [15:0] dx_q, dy_q, oy_q, fg_q;
	logic [7:0] scale_q;
	logic rect_valid_q;
	rect_t rect_q;

	logic out_free, start, dot_step, emit, rest_empty;
	logic [10:0] bg_w, bg_h;
	rect_t cand;

	function automatic rect_t clip_rect(input logic [15:0] x, input logic [15:0] y,
		input logic [10:0] w, input logic [10:0] h, input logic [15:0] color,
		input logic [8:0] sw, input logic [8:0] sh);
		rect_t r;
		logic [8:0] aw, ah;
		aw = sw - x[8:0];
		ah = sh - y[8:0];
		if (w == 11'd0 || h == 11'd0 || x >= {7'd0, sw} || y >= {7'd0, sh}) begin
			r = ERR_RECT;
		end else begin
			r.rect_x = x[8:0];
			r.rect_y = y[8:0];
			r.rect_w = (w > {2'b00, aw}) ? aw : w[8:0];
			r.rect_h = (h > {2'b00, ah}) ? ah : h[8:0];
			r.rect_color = color;
			r.status = STATUS_OK;
			r.last = 1'b0;
		end
		clip_rect = r;
	endfunction

	assign out_free = !rect_valid_q || !rect_stall;
	assign start = job_valid && !busy_q && out_free;
	assign dot_step = busy_q && out_free;
	assign job_pop = start;
	assign rest_empty = (mask_q[GLYPH_DOTS-1:1] == '0);

	// Cell is 6 by 8 dots of scale pixels each.
	assign bg_w = {1'b0, job.scale, 2'b00} + {2'b00, job.scale, 1'b0};
	assign bg_h = {job.scale, 3'b000};

	always_comb begin
		if (busy_q) begin
			cand = clip_rect(dx_q, dy_q, {3'b000, scale_q}, {3'b000, scale_q}, fg_q,
				screen_width, screen_height);
			if (cand.status == STATUS_OK) cand.last = rest_empty;
			emit = dot_step && mask_q[0];
		end else if (job.scale_zero) begin
			cand = ERR_RECT;
			emit = start;
		end else begin
			cand = clip_rect(job.origin_x, job.origin_y, bg_w, bg_h, job.bg_color,
				screen_width, screen_height);
			if (cand.status == STATUS_OK) cand.last = (job.glyph == '0);
			emit = start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rect_valid_q <= 1'b0;
		end else begin
			if (out_free) rect_valid_q <= emit;
			if (start) begin
				busy_q <= !job.scale_zero && (cand.status == STATUS_OK) && (job.glyph != '0);
			end else if (dot_step) begin
				if (rest_empty || (mask_q[0] && cand.status == STATUS_ARG_ERROR)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) rect_q <= cand;
		if (start) begin
			mask_q <= job.glyph;
			row_q <= 3'd0;
			dx_q <= job.origin_x;
			dy_q <= job.origin_y;
			oy_q <= job.origin_y;
			scale_q <= job.scale;
			fg_q <= job.fg_color;
		end else if (dot_step) begin
			mask_q <= mask_q >> 1;
			if (row_q == 3'(GLYPH_ROWS - 1)) begin
				row_q <= 3'd0;
				dx_q <= dx_q + {8'd0, scale_q};
				dy_q <= oy_q;
			end else begin
				row_q <= row_q + 3'd1;
				dy_q <= dy_q + {8'd0, scale_q};
			end
		end
	end

	assign rect_valid = rect_valid_q;
	assign rect = rect_q;

	`SGR_ASSERT(a_error_is_last, (rect_valid_q && rect_q.status) |-> rect_q.last,
		"error result not marked last")
	`SGR_ASSERT(a_busy_has_dots, busy_q |-> (mask_q != '0), "walking a glyph with no dots left")
	`SGR_ASSERT(a_error_ends_walk, (emit && busy_q && cand.status) |=> !busy_q,
		"dot walk continued after an error")

endmodule

@@ rtl/core/scaled_glyph_rect_renderer_top.sv @@
// Top level of the scaled glyph rectangle renderer: screen-size registers,
// front end with queue and back end. Depends on sgr_pkg, sgr_front, sgr_back.
//
// Use: each transfer on the req channel is one character draw request. It
// yields a stream of fill rectangles on the rect channel: first the cell
// background (6*scale by 8*scale in bg_color), then one scale by scale
// rectangle in fg_color for every lit dot of the 5x7 glyph, column by
// column and top row first. The final rectangle of a character has last set.
// Rectangles are clipped to screen_width and screen_height; a zero scale or
// a rectangle starting off screen gives one error result (status set, last
// set, other fields zero) that ends that character's stream.
// The back end emits the background of a request, then its dot walker steps
// through the glyph bits in order up to the highest lit dot and takes no new
// request until it is done. Blank glyphs and errors go at one request per
// cycle while no offered result is stalled. With an empty queue and an idle
// walker the first result passes through the queue entry and then the output
// register before it is offered. The queue in front takes further requests
// while the walker runs and raises req_stall only when it is full.
// While a result is offered, rect_stall makes the output register hold it and
// pauses the walker; the queue keeps filling. Reset empties the queue, aborts
// any walk and sets the screen to 240 by 135; configuration writes are taken
// at any edge with cfg_we high and are meant for idle periods.
module scaled_glyph_rect_renderer_top
	import sgr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req,
	output logic                   rect_valid,
	input  logic                   rect_stall,
	output rect_t                  rect
);

	logic [8:0] screen_width_q, screen_height_q;
	logic job_valid, job_pop;
	job_t job;

	// Writes to an index past the two registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sgr_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.job_valid(job_valid),
		.job_pop(job_pop),
		.job(job)
	);

	sgr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.screen_width(screen_width_q),
		.screen_height(screen_height_q),
		.job_valid(job_valid),
		.job_pop(job_pop),
		.job(job),
		.rect_valid(rect_valid),
		.rect_stall(rect_stall),
		.rect(rect)
	);

endmodule
